// ----- rtl/bgr_pkg.sv -----
// Shared types, codes and constants of the button gesture recogniser.
package bgr_pkg;

  localparam int MaxEvents = 8;
  localparam int EvCntW    = 4;
  localparam int EvIdxW    = 3;
  localparam int BtnW      = 3;
  localparam int IdW       = 8;
  localparam int TimeW     = 32;
  localparam int MsW       = 16;
  localparam int MaskW     = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [MaskW-1:0] ClickMaskRst  = 8'd255;
  localparam logic [MaskW-1:0] DblMaskRst    = 8'd0;
  localparam logic [MaskW-1:0] LongMaskRst   = 8'd0;
  localparam logic [MaskW-1:0] RepeatMaskRst = 8'd0;
  localparam logic [MsW-1:0]   LongTimeRst   = 16'd500;
  localparam logic [MsW-1:0]   RepeatTimeRst = 16'd100;
  localparam logic [MsW-1:0]   DblTimeRst    = 16'd300;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_LONG,
    PH_WAIT,
    PH_SECOND
  } phase_t;

  typedef enum logic [2:0] {
    EV_PRESS,
    EV_RELEASE,
    EV_CLICK,
    EV_DOUBLE,
    EV_LONG,
    EV_REPEAT
  } ev_code_t;

  typedef enum logic [1:0] {
    FN_TICK,
    FN_PRESS,
    FN_RELEASE
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLICK_MASK,
    CFG_DBL_MASK,
    CFG_LONG_MASK,
    CFG_REPEAT_MASK,
    CFG_LONG_TIME,
    CFG_REPEAT_TIME,
    CFG_DBL_TIME
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_WALK,
    CS_DRAIN
  } ctl_state_t;

  // Item token handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic [1:0]       func;
    logic [IdW-1:0]   button_id;
    logic [TimeW-1:0] now_ms;
  } tok_t;

  typedef struct packed {
    logic           click_en;
    logic           dbl_en;
    logic           long_en;
    logic           repeat_en;
    logic [MsW-1:0] long_time;
    logic [MsW-1:0] repeat_time;
    logic [MsW-1:0] dbl_time;
  } cell_cfg_t;

  // Up to two events from the active cell; all zero from an idle cell
  typedef struct packed {
    logic            ev0_vld;
    ev_code_t        ev0_code;
    logic            ev1_vld;
    ev_code_t        ev1_code;
    logic [BtnW-1:0] button;
  } cell_ev_t;

  typedef struct packed {
    logic [BtnW-1:0] button;
    ev_code_t        code;
  } evbuf_ent_t;

endpackage

// ----- rtl/bgr_ifs.sv -----
// Valid/ready channel interfaces for input items and result items.
interface bgr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  button_id;
  logic [31:0] now_ms;

  modport source (output valid, func, button_id, now_ms, input ready);
  modport sink (input valid, func, button_id, now_ms, output ready);
endinterface

interface bgr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_button;
  logic [2:0] event_code;
  logic       last_event;

  modport source (output valid, event_button, event_code, last_event, input ready);
  modport sink (input valid, event_button, event_code, last_event, output ready);
endinterface

// ----- rtl/bgr_cell.sv -----
// One button cell: phase and time stamps, acting when the item token passes.
module bgr_cell #(
  parameter int CELL_ID = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bgr_pkg::tok_t      tok_in,
  output bgr_pkg::tok_t      tok_out,
  input  bgr_pkg::cell_cfg_t cfg,
  output bgr_pkg::cell_ev_t  ev
);
  import bgr_pkg::*;

  localparam logic [BtnW-1:0] CellBtn = BtnW'(CELL_ID);
  localparam logic [IdW-1:0]  CellId  = IdW'(CELL_ID);

  tok_t             tok_r;
  phase_t           phase_r, phase_nxt;
  logic [TimeW-1:0] prs_r, prs_nxt;
  logic [TimeW-1:0] rel_r, rel_nxt;
  logic [TimeW-1:0] rep_r, rep_nxt;
  logic [TimeW-1:0] dt_prs, dt_rel, dt_rep;
  logic             hit;

  assign dt_prs  = tok_r.now_ms - prs_r;
  assign dt_rel  = tok_r.now_ms - rel_r;
  assign dt_rep  = tok_r.now_ms - rep_r;
  assign hit     = tok_r.vld && (tok_r.button_id == CellId);
  assign tok_out = tok_r;

  always_comb begin
    phase_nxt = phase_r;
    prs_nxt   = prs_r;
    rel_nxt   = rel_r;
    rep_nxt   = rep_r;
    ev        = '0;
    if (tok_r.vld) begin
      ev.button = CellBtn;
    end
    if (tok_r.vld && tok_r.func == FN_TICK) begin
      case (phase_r)
        PH_PRESSED: begin
          if (cfg.long_en && dt_prs >= TimeW'(cfg.long_time)) begin
            phase_nxt   = PH_LONG;
            rep_nxt     = tok_r.now_ms;
            ev.ev0_vld  = 1'b1;
            ev.ev0_code = EV_LONG;
          end
        end
        PH_LONG: begin
          if (cfg.repeat_en && dt_rep >= TimeW'(cfg.repeat_time)) begin
            rep_nxt     = tok_r.now_ms;
            ev.ev0_vld  = 1'b1;
            ev.ev0_code = EV_REPEAT;
          end
        end
        PH_WAIT: begin
          if (dt_rel >= TimeW'(cfg.dbl_time)) begin
            phase_nxt   = PH_IDLE;
            ev.ev0_vld  = cfg.click_en;
            ev.ev0_code = EV_CLICK;
          end
        end
        default: ;
      endcase
    end else if (hit && tok_r.func == FN_PRESS) begin
      if (phase_r == PH_IDLE || phase_r == PH_WAIT) begin
        phase_nxt   = (phase_r == PH_IDLE) ? PH_PRESSED : PH_SECOND;
        prs_nxt     = tok_r.now_ms;
        ev.ev0_vld  = 1'b1;
        ev.ev0_code = EV_PRESS;
      end
    end else if (hit && tok_r.func == FN_RELEASE) begin
      case (phase_r)
        PH_PRESSED: begin
          ev.ev0_vld  = 1'b1;
          ev.ev0_code = EV_RELEASE;
          if (cfg.dbl_en) begin
            phase_nxt = PH_WAIT;
            rel_nxt   = tok_r.now_ms;
          end else begin
            phase_nxt   = PH_IDLE;
            ev.ev1_vld  = cfg.click_en;
            ev.ev1_code = EV_CLICK;
          end
        end
        PH_LONG: begin
          phase_nxt   = PH_IDLE;
          ev.ev0_vld  = 1'b1;
          ev.ev0_code = EV_RELEASE;
        end
        PH_SECOND: begin
          phase_nxt   = PH_IDLE;
          ev.ev0_vld  = 1'b1;
          ev.ev0_code = EV_RELEASE;
          ev.ev1_vld  = 1'b1;
          ev.ev1_code = EV_DOUBLE;
        end
        default: ;
      endcase
    end
  end

  // Time stamps are only read in phases that write them on entry
  always_ff @(posedge clk) begin
    tok_r.func      <= tok_in.func;
    tok_r.button_id <= tok_in.button_id;
    tok_r.now_ms    <= tok_in.now_ms;
    prs_r           <= prs_nxt;
    rel_r           <= rel_nxt;
    rep_r           <= rep_nxt;
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      phase_r   <= PH_IDLE;
    end else begin
      tok_r.vld <= tok_in.vld;
      phase_r   <= phase_nxt;
    end
  end

endmodule

// ----- rtl/button_gesture_recognizer_core.sv -----
// Top level of the button gesture recogniser: cell chain, event buffer and control.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------
//  in_ch   | in  | valid/ready       | func, button_id, now_ms
//  out_ch  | out | valid/ready       | event_button, event_code, last_event
//  cfg_*   | in  | cfg_we, no stall  | cfg_idx, cfg_wdata (16 bits)
//
// An item's token walks down the cell chain, one cell a cycle; the item's
// events are then delivered on out_ch, one per accepted handshake.
// Synchronous reset clears every phase to idle and loads the default config.
// A stalled out_ch holds the current event; no new item is taken until every
// event of the previous one has been delivered.
module button_gesture_recognizer_core #(
  parameter int BUTTONS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bgr_in_if.sink                          in_ch,
  bgr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bgr_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [bgr_pkg::CfgDataW-1:0]    cfg_wdata
);
  import bgr_pkg::*;

  // Configuration registers
  logic [MaskW-1:0] click_mask_r, dbl_mask_r, long_mask_r, repeat_mask_r;
  logic [MsW-1:0]   long_time_r, repeat_time_r, dbl_time_r;

  ctl_state_t       state_r, state_nxt;
  tok_t             head;
  tok_t             tok_q [BUTTONS];
  cell_ev_t         cev [BUTTONS];
  cell_ev_t         ev_all;
  logic [BUTTONS-1:0] tok_vld;
  logic             in_acc, out_acc, walk_done, is_last;

  evbuf_ent_t       buf_r [MaxEvents];
  evbuf_ent_t       buf_nxt [MaxEvents];
  logic [EvCntW-1:0] cnt_r, cnt_nxt, cnt_mid;
  logic [EvIdxW-1:0] rd_r, rd_nxt;

  // Write a register; out-of-list indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_mask_r  <= ClickMaskRst;
      dbl_mask_r    <= DblMaskRst;
      long_mask_r   <= LongMaskRst;
      repeat_mask_r <= RepeatMaskRst;
      long_time_r   <= LongTimeRst;
      repeat_time_r <= RepeatTimeRst;
      dbl_time_r    <= DblTimeRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_CLICK_MASK:  click_mask_r  <= cfg_wdata[MaskW-1:0];
        CFG_DBL_MASK:    dbl_mask_r    <= cfg_wdata[MaskW-1:0];
        CFG_LONG_MASK:   long_mask_r   <= cfg_wdata[MaskW-1:0];
        CFG_REPEAT_MASK: repeat_mask_r <= cfg_wdata[MaskW-1:0];
        CFG_LONG_TIME:   long_time_r   <= cfg_wdata;
        CFG_REPEAT_TIME: repeat_time_r <= cfg_wdata;
        CFG_DBL_TIME:    dbl_time_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // Launch the item token into the first cell on acceptance
  assign head.vld       = in_acc;
  assign head.func      = in_ch.func;
  assign head.button_id = in_ch.button_id;
  assign head.now_ms    = in_ch.now_ms;

  // Cell chain: each cell hands the token to its neighbour every cycle
  for (genvar i = 0; i < BUTTONS; i++) begin : g_cell
    cell_cfg_t  ccfg;
    logic [3:0] en_bits;

    // Buttons beyond the mask width have every enable cleared
    if (i < MaskW) begin : g_en
      assign en_bits = {click_mask_r[i], dbl_mask_r[i], long_mask_r[i], repeat_mask_r[i]};
    end else begin : g_noen
      assign en_bits = 4'b0000;
    end

    assign ccfg = '{click_en: en_bits[3], dbl_en: en_bits[2], long_en: en_bits[1],
                    repeat_en: en_bits[0], long_time: long_time_r,
                    repeat_time: repeat_time_r, dbl_time: dbl_time_r};

    bgr_cell #(.CELL_ID(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  ((i == 0) ? head : tok_q[(i == 0) ? 0 : i - 1]),
      .tok_out (tok_q[i]),
      .cfg     (ccfg),
      .ev      (cev[i])
    );

    assign tok_vld[i] = tok_q[i].vld;
  end

  assign walk_done = tok_vld[BUTTONS-1];

  // Only the cell holding the token drives non-zero events
  always_comb begin
    ev_all = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      ev_all = ev_all | cev[i];
    end
  end

  // Append up to two events a cycle; drop anything past the buffer depth
  always_comb begin
    buf_nxt = buf_r;
    cnt_mid = cnt_r;
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    case (state_r)
      CS_IDLE: begin
        cnt_nxt = '0;
        rd_nxt  = '0;
      end
      CS_WALK: begin
        if (ev_all.ev0_vld && cnt_r < EvCntW'(MaxEvents)) begin
          buf_nxt[cnt_r[EvIdxW-1:0]] = '{button: ev_all.button, code: ev_all.ev0_code};
          cnt_mid = cnt_r + 1'b1;
        end
        cnt_nxt = cnt_mid;
        if (ev_all.ev1_vld && cnt_mid < EvCntW'(MaxEvents)) begin
          buf_nxt[cnt_mid[EvIdxW-1:0]] = '{button: ev_all.button, code: ev_all.ev1_code};
          cnt_nxt = cnt_mid + 1'b1;
        end
      end
      CS_DRAIN: begin
        if (out_acc) begin
          rd_nxt = rd_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign is_last = (EvCntW'(rd_r) == cnt_r - 1'b1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_acc) begin
          state_nxt = CS_WALK;
        end
      end
      CS_WALK: begin
        if (walk_done) begin
          state_nxt = (cnt_nxt == '0) ? CS_IDLE : CS_DRAIN;
        end
      end
      CS_DRAIN: begin
        if (out_acc && is_last) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ch.ready         = 1'b0;
    out_ch.valid        = 1'b0;
    out_ch.event_button = buf_r[rd_r].button;
    out_ch.event_code   = buf_r[rd_r].code;
    out_ch.last_event   = is_last;
    case (state_r)
      CS_IDLE:  in_ch.ready  = 1'b1;
      CS_DRAIN: out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      cnt_r   <= '0;
      rd_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  // No token may be in the chain while a new item can be taken
  a_ready_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (tok_vld == '0))
    else $error("item accepted while token still in chain");

  // At most one cell holds the token
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one cell active");

  // An accepted item reaches the first cell next cycle
  a_token_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> tok_vld[0])
    else $error("token not launched");

  // The event buffer never overfills and draining stays inside it
  a_buf_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (cnt_r != '0 && cnt_r <= EvCntW'(MaxEvents) && EvCntW'(rd_r) < cnt_r))
    else $error("event buffer read out of range");

endmodule

// ----- tb/bgr_check_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the gesture recogniser: per-button gesture prediction and event checking.
package bgr_check_pkg;
  import bgr_pkg::*;

  localparam int NumButtons = 8;

  typedef struct packed {
    logic [BtnW-1:0] button;
    ev_code_t        code;
    logic            last;
  } gesture_ev_t;

  class gesture_scoreboard;
    phase_t           phase [NumButtons];
    logic [TimeW-1:0] press_stamp [NumButtons];
    logic [TimeW-1:0] release_stamp [NumButtons];
    logic [TimeW-1:0] repeat_stamp [NumButtons];
    logic [MaskW-1:0] click_en, dbl_en, long_en, repeat_en;
    logic [MsW-1:0]   long_ms, repeat_ms, dbl_ms;
    gesture_ev_t      burst[$];
    gesture_ev_t      awaited[$];
    int               errors;

    function new();
      for (int b = 0; b < NumButtons; b++) begin
        phase[b]         = PH_IDLE;
        press_stamp[b]   = '0;
        release_stamp[b] = '0;
        repeat_stamp[b]  = '0;
      end
      click_en  = ClickMaskRst;
      dbl_en    = DblMaskRst;
      long_en   = LongMaskRst;
      repeat_en = RepeatMaskRst;
      long_ms   = LongTimeRst;
      repeat_ms = RepeatTimeRst;
      dbl_ms    = DblTimeRst;
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_CLICK_MASK:  click_en  = data[MaskW-1:0];
        CFG_DBL_MASK:    dbl_en    = data[MaskW-1:0];
        CFG_LONG_MASK:   long_en   = data[MaskW-1:0];
        CFG_REPEAT_MASK: repeat_en = data[MaskW-1:0];
        CFG_LONG_TIME:   long_ms   = data[MsW-1:0];
        CFG_REPEAT_TIME: repeat_ms = data[MsW-1:0];
        CFG_DBL_TIME:    dbl_ms    = data[MsW-1:0];
        default: ;
      endcase
    endfunction

    // Anything past the eighth event of one item is dropped
    function void add_event(int b, ev_code_t code);
      gesture_ev_t ev;
      if (burst.size() >= MaxEvents) return;
      ev.button = BtnW'(b);
      ev.code   = code;
      ev.last   = 1'b0;
      burst.push_back(ev);
    endfunction

    function void note_item(logic [1:0] kind, logic [IdW-1:0] id, logic [TimeW-1:0] now);
      logic [TimeW-1:0] held;
      burst.delete();
      if (kind == FN_TICK) begin
        for (int b = 0; b < NumButtons; b++) begin
          case (phase[b])
            PH_PRESSED: begin
              held = now - press_stamp[b];
              if (long_en[b] && held >= TimeW'(long_ms)) begin
                phase[b]        = PH_LONG;
                repeat_stamp[b] = now;
                add_event(b, EV_LONG);
              end
            end
            PH_LONG: begin
              held = now - repeat_stamp[b];
              if (repeat_en[b] && held >= TimeW'(repeat_ms)) begin
                repeat_stamp[b] = now;
                add_event(b, EV_REPEAT);
              end
            end
            PH_WAIT: begin
              held = now - release_stamp[b];
              if (held >= TimeW'(dbl_ms)) begin
                phase[b] = PH_IDLE;
                if (click_en[b]) add_event(b, EV_CLICK);
              end
            end
            default: ;
          endcase
        end
      end else if (kind == FN_PRESS && id < NumButtons) begin
        if (phase[id] == PH_IDLE || phase[id] == PH_WAIT) begin
          if (phase[id] == PH_IDLE) phase[id] = PH_PRESSED;
          else phase[id] = PH_SECOND;
          press_stamp[id] = now;
          add_event(id, EV_PRESS);
        end
      end else if (kind == FN_RELEASE && id < NumButtons) begin
        case (phase[id])
          PH_PRESSED: begin
            add_event(id, EV_RELEASE);
            if (dbl_en[id]) begin
              phase[id]         = PH_WAIT;
              release_stamp[id] = now;
            end else begin
              phase[id] = PH_IDLE;
              if (click_en[id]) add_event(id, EV_CLICK);
            end
          end
          PH_LONG: begin
            phase[id] = PH_IDLE;
            add_event(id, EV_RELEASE);
          end
          PH_SECOND: begin
            phase[id] = PH_IDLE;
            add_event(id, EV_RELEASE);
            add_event(id, EV_DOUBLE);
          end
          default: ;
        endcase
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[k]) awaited.push_back(burst[k]);
    endfunction

    function void check_event(logic [BtnW-1:0] button, logic [2:0] code, logic last);
      gesture_ev_t want;
      if (awaited.size() == 0) begin
        errors++;
        $error("unexpected event: event_button %0d, event_code %0d, last_event %0b",
               button, code, last);
        return;
      end
      want = awaited.pop_front();
      if (button !== want.button) begin
        errors++;
        $error("event_button: expected %0d, actual %0d", want.button, button);
      end
      if (code !== want.code) begin
        errors++;
        $error("event_code: expected %0d, actual %0d", want.code, code);
      end
      if (last !== want.last) begin
        errors++;
        $error("last_event: expected %0b, actual %0b", want.last, last);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top-level testbench of the button gesture recogniser: stimulus, handshakes and verdict.
module tb_top;
  import bgr_pkg::*;
  import bgr_check_pkg::*;

  localparam int IdlePct       = 22;
  localparam int HoldOffCycles = 250;   // long receiver stall, fills the block
  localparam int SettleCycles  = 24;    // covers the chain walk, with a margin on top
  localparam int DrainCycles   = 40;
  localparam int WatchdogLimit = 3000;  // cycles with no item moving on either channel

  // Codes the package has no name for: the unused item kind and the spare register slot
  localparam logic [1:0]         FnSpare     = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  // Shared knobs: gaps_on toggles random idling on both sides, squeeze_req
  // asks the receiver for its one long stall.
  logic gaps_on;
  logic squeeze_req;

  // Running millisecond clock that the well-formed items carry
  logic [TimeW-1:0] clock_ms;

  gesture_scoreboard board;

  bgr_in_if  in_ch();
  bgr_out_if out_ch();

  button_gesture_recognizer_core #(
    .BUTTONS (NumButtons)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one item and hold it until the block takes it. Valid is left high on
  // return so that a following item goes out back to back; a random gap drops
  // it first.
  task automatic send_item(input logic [1:0] kind, input logic [IdW-1:0] id,
                           input logic [TimeW-1:0] stamp);
    if (gaps_on && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= kind;
    in_ch.button_id <= id;
    in_ch.now_ms    <= stamp;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    board.note_item(kind, id, stamp);
  endtask

  // Drop valid, wait for every predicted event to come out, then let the
  // chain finish walking any item that produced nothing.
  task automatic settle(input int cycles);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // Write one register; the write enable stays high so writes can follow back to back
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [MaskW-1:0] click_m, input logic [MaskW-1:0] dbl_m,
                              input logic [MaskW-1:0] long_m, input logic [MaskW-1:0] rep_m,
                              input logic [MsW-1:0] long_t, input logic [MsW-1:0] rep_t,
                              input logic [MsW-1:0] dbl_t);
    write_reg(CFG_CLICK_MASK,  CfgDataW'(click_m));
    write_reg(CFG_DBL_MASK,    CfgDataW'(dbl_m));
    write_reg(CFG_LONG_MASK,   CfgDataW'(long_m));
    write_reg(CFG_REPEAT_MASK, CfgDataW'(rep_m));
    write_reg(CFG_LONG_TIME,   long_t);
    write_reg(CFG_REPEAT_TIME, rep_t);
    write_reg(CFG_DBL_TIME,    dbl_t);
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks, presses and releases on real buttons with the clock moving
  // forward by up to span ms; the rest is noise of any kind, id and time.
  // Noise does not count towards the target.
  task automatic run_random(input int target, input int unsigned span);
    int               done;
    int unsigned      pick;
    logic [1:0]       kind;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] stamp;
    done = 0;
    while (done < target) begin
      pick     = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(span, 0);
      id       = IdW'($urandom_range(NumButtons - 1));
      stamp    = clock_ms;
      if (pick < 8) begin
        kind  = 2'($urandom_range(3));
        id    = IdW'($urandom_range(255));
        stamp = $urandom;
      end else begin
        done++;
        if (pick < 40) kind = FN_TICK;
        else if (pick < 72) kind = FN_PRESS;
        else kind = FN_RELEASE;
      end
      send_item(kind, id, stamp);
    end
  endtask

  // Receiver: check every event taken, then pick ready for the next cycle.
  // The one long hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin : receiver
    int hold_left;
    bit squeezed;
    hold_left    = 0;
    squeezed     = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_event(out_ch.event_button, out_ch.event_code, out_ch.last_event);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (gaps_on) begin
        out_ch.ready <= ($urandom_range(99) >= IdlePct);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("FAIL button_gesture_recognizer_core");
    $finish;
  end

  initial begin : stimulus
    board = new();

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_CLICK_MASK;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FN_TICK;
    in_ch.button_id <= '0;
    in_ch.now_ms    <= '0;
    gaps_on         <= 1'b1;
    squeeze_req     <= 1'b0;
    clock_ms         = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a plain click, a press while pressed, a release while idle
    send_item(FN_PRESS,   8'd4, 32'd100);
    send_item(FN_PRESS,   8'd4, 32'd101);
    send_item(FN_RELEASE, 8'd4, 32'd110);
    send_item(FN_RELEASE, 8'd4, 32'd111);
    settle(SettleCycles);

    // Double click on buttons 0..3 only, everything else enabled, short times
    program_regs(8'hFF, 8'h0F, 8'hFF, 8'hFF, 16'd40, 16'd20, 16'd40);

    // Double click, with a release while waiting and a press while second pressed
    send_item(FN_PRESS,   8'd0, 32'd120);
    send_item(FN_RELEASE, 8'd0, 32'd130);
    send_item(FN_RELEASE, 8'd0, 32'd131);
    send_item(FN_PRESS,   8'd0, 32'd140);
    send_item(FN_PRESS,   8'd0, 32'd141);
    send_item(FN_RELEASE, 8'd0, 32'd150);
    // Single click that times out on a tick exactly at the wait limit
    send_item(FN_PRESS,   8'd1, 32'd200);
    send_item(FN_RELEASE, 8'd1, 32'd210);
    send_item(FN_TICK,    8'd0, 32'd250);
    // Long press and hold repeat across the wrap of the millisecond clock
    send_item(FN_PRESS,   8'd5, 32'hFFFF_FFF0);
    send_item(FN_TICK,    8'd0, 32'h0000_0018);
    send_item(FN_PRESS,   8'd5, 32'h0000_0020);
    send_item(FN_TICK,    8'd0, 32'h0000_0030);
    send_item(FN_RELEASE, 8'd5, 32'h0000_0040);
    // Out-of-range buttons and the unused kind do nothing
    send_item(FN_PRESS,   8'd8,  32'h0000_0050);
    send_item(FN_RELEASE, 8'hFF, 32'h0000_0051);
    send_item(FnSpare,    8'd0,  32'h0000_0052);
    // Every button long pressed on one tick: a full burst of events
    for (int b = 0; b < NumButtons; b++) send_item(FN_PRESS, IdW'(b), 32'h0000_0100);
    send_item(FN_TICK, 8'd0, 32'h0000_0128);
    settle(SettleCycles);

    // Steady stretch, no idling on either side; clock wraps part way through
    gaps_on <= 1'b0;
    program_regs(MaskW'($urandom_range(255)), MaskW'($urandom_range(255)),
                 MaskW'($urandom_range(255)), MaskW'($urandom_range(255)),
                 MsW'($urandom_range(300, 20)), MsW'($urandom_range(300, 20)),
                 MsW'($urandom_range(300, 20)));
    clock_ms = 32'hFFFF_FC00;
    run_random(20, 150);
    settle(SettleCycles);

    // All times zero: every tick fires; hold the receiver off so the block backs up
    gaps_on <= 1'b1;
    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd0, 16'd0);
    squeeze_req <= 1'b1;
    run_random(15, 3);
    settle(SettleCycles);

    // Longest times with wide clock steps; the spare register slot gets a write too
    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CfgIdxSpare, CfgDataW'($urandom_range(16'hFFFF)));
    cfg_we <= 1'b0;
    run_random(12, 30000);
    settle(SettleCycles);

    program_regs(MaskW'($urandom_range(255)), MaskW'($urandom_range(255)),
                 MaskW'($urandom_range(255)), MaskW'($urandom_range(255)),
                 MsW'($urandom_range(400)), MsW'($urandom_range(400)),
                 MsW'($urandom_range(400)));
    run_random(15, 200);
    settle(SettleCycles);

    // Everything masked off: only presses and releases remain
    program_regs(8'h00, 8'h00, 8'h00, 8'h00, MsW'($urandom_range(400)),
                 MsW'($urandom_range(400)), MsW'($urandom_range(400)));
    run_random(10, 100);

    settle(DrainCycles);
    if (board.errors == 0) begin
      $display("PASS button_gesture_recognizer_core");
    end else begin
      $display("FAIL button_gesture_recognizer_core");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bgr_pkg.sv
rtl/bgr_ifs.sv
rtl/bgr_cell.sv
rtl/button_gesture_recognizer_core.sv
tb/bgr_check_pkg.sv
tb/tb_top.sv
